[rtl/tesp_pkg.sv]
// Shared types and constants of the tagged element stream parser.
package tesp_pkg;

  // Result status codes
  localparam logic [2:0] ST_HEADER  = 3'd0;
  localparam logic [2:0] ST_DONE    = 3'd1;
  localparam logic [2:0] ST_PAYLOAD = 3'd2;
  localparam logic [2:0] ST_OVERRUN = 3'd3;
  localparam logic [2:0] ST_IGNORED = 3'd4;
  localparam logic [2:0] ST_TRUNC   = 3'd5;

  // Length decision modes
  localparam logic [1:0] MODE_WHOLE = 2'd0;
  localparam logic [1:0] MODE_UPPER = 2'd1;
  localparam logic [1:0] MODE_GUESS = 2'd2;
  localparam logic [1:0] MODE_NEXT4 = 2'd3;

  localparam logic [31:0] TAG_NEXT4 = 32'd65538;

  localparam int NUM_WHOLE_TAGS = 9;
  localparam int NUM_UPPER_TAGS = 5;

  localparam logic [31:0] WHOLE_TAGS [NUM_WHOLE_TAGS] = '{
    32'd5255174, 32'd3758161918, 32'd1081312, 32'd1191942, 32'd4206598,
    32'd1060870, 32'd3747846, 32'd1454086, 32'd1323014
  };

  localparam logic [31:0] UPPER_TAGS [NUM_UPPER_TAGS] = '{
    32'd2, 32'd131074, 32'd196610, 32'd1048578, 32'd1179650
  };

  localparam logic [7:0] PRINT_LO = 8'd32;
  localparam logic [7:0] PRINT_HI = 8'd126;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] element_tag;
    logic [31:0] element_word;
    logic [31:0] payload_length;
    logic [7:0]  payload_byte;
    logic        end_of_element;
    logic        length_guessed;
  } result_t;

endpackage

[rtl/tesp_len_sel.sv]
// Length mode decode from the tag and the second header word.
module tesp_len_sel (
  input  logic [31:0] tag,
  input  logic [31:0] word,
  output logic [1:0]  mode
);

  logic is_whole;
  logic is_upper;
  logic printable;

  always_comb begin
    is_whole = 1'b0;
    is_upper = 1'b0;
    for (int k = 0; k < tesp_pkg::NUM_WHOLE_TAGS; k++) begin
      if (tag == tesp_pkg::WHOLE_TAGS[k]) is_whole = 1'b1;
    end
    for (int k = 0; k < tesp_pkg::NUM_UPPER_TAGS; k++) begin
      if (tag == tesp_pkg::UPPER_TAGS[k]) is_upper = 1'b1;
    end
    printable = (word[7:0]  >= tesp_pkg::PRINT_LO) && (word[7:0]  <= tesp_pkg::PRINT_HI) &&
                (word[15:8] >= tesp_pkg::PRINT_LO) && (word[15:8] <= tesp_pkg::PRINT_HI);
  end

  always_comb begin
    priority if (tag == tesp_pkg::TAG_NEXT4) begin
      mode = tesp_pkg::MODE_NEXT4;
    end else if (is_whole) begin
      mode = tesp_pkg::MODE_WHOLE;
    end else if (printable && is_upper) begin
      mode = tesp_pkg::MODE_UPPER;
    end else if (printable) begin
      mode = tesp_pkg::MODE_GUESS;
    end else begin
      mode = tesp_pkg::MODE_WHOLE;
    end
  end

endmodule

[rtl/tesp_core.sv]
// Parse state and per-byte result logic.
module tesp_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [7:0]          data_byte,
  input  logic [31:0]         region_length,
  output tesp_pkg::result_t   res
);

  localparam logic [1:0] PH_TAG     = 2'd0;
  localparam logic [1:0] PH_WORD    = 2'd1;
  localparam logic [1:0] PH_LEN     = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;

  logic [1:0]  phase_r, phase_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [31:0] tag_r, tag_nxt;
  logic [31:0] word_r, word_nxt;
  logic [31:0] len_r, len_nxt;
  logic        guess_r, guess_nxt;
  logic [31:0] left_r, left_nxt;
  logic [31:0] pos_r, pos_nxt;
  logic        halted_r, halted_nxt;

  logic        ignored;
  logic [31:0] pos_inc;
  logic [31:0] remaining;
  logic        start;
  logic [31:0] lane;
  logic [31:0] tag_cur;
  logic [31:0] word_cur;
  logic [31:0] len_cur;
  logic        field_done;
  logic [1:0]  mode;
  logic [31:0] fin_len;
  logic        fin_guess;
  logic        do_finish;

  tesp_len_sel u_len_sel (
    .tag  (tag_r),
    .word (word_cur),
    .mode (mode)
  );

  always_comb begin
    ignored   = halted_r || (pos_r >= region_length);
    pos_inc   = pos_r + 32'd1;
    remaining = region_length - pos_inc;
    start     = (phase_r == PH_TAG) && (idx_r == 2'd0);
    unique case (idx_r)
      2'd0: lane = {24'd0, data_byte};
      2'd1: lane = {16'd0, data_byte, 8'd0};
      2'd2: lane = {8'd0, data_byte, 16'd0};
      2'd3: lane = {data_byte, 24'd0};
    endcase
    tag_cur  = (start ? 32'd0 : tag_r) | ((phase_r == PH_TAG) ? lane : 32'd0);
    word_cur = (start ? 32'd0 : word_r) | ((phase_r == PH_WORD) ? lane : 32'd0);
    len_cur  = (start ? 32'd0 : len_r) | ((phase_r == PH_LEN) ? lane : 32'd0);
    field_done = (idx_r == 2'd3);

    // Length chosen when the header completes
    fin_len   = len_cur;
    fin_guess = start ? 1'b0 : guess_r;
    if (phase_r == PH_WORD) begin
      fin_len   = (mode == tesp_pkg::MODE_WHOLE) ? word_cur : {16'd0, word_cur[31:16]};
      fin_guess = (mode == tesp_pkg::MODE_GUESS);
    end
    do_finish = field_done &&
                (((phase_r == PH_WORD) && (mode != tesp_pkg::MODE_NEXT4)) ||
                 (phase_r == PH_LEN));
  end

  always_comb begin
    phase_nxt  = phase_r;
    idx_nxt    = idx_r;
    tag_nxt    = tag_r;
    word_nxt   = word_r;
    len_nxt    = len_r;
    guess_nxt  = guess_r;
    left_nxt   = left_r;
    pos_nxt    = pos_r;
    halted_nxt = halted_r;
    res        = '0;

    if (ignored) begin
      res.status = tesp_pkg::ST_IGNORED;
    end else if (phase_r == PH_PAYLOAD) begin
      pos_nxt            = pos_inc;
      left_nxt           = left_r - 32'd1;
      res.status         = tesp_pkg::ST_PAYLOAD;
      res.element_tag    = tag_r;
      res.element_word   = word_r;
      res.payload_length = len_r;
      res.payload_byte   = data_byte;
      res.length_guessed = guess_r;
      if (left_r == 32'd1) begin
        res.end_of_element = 1'b1;
        phase_nxt          = PH_TAG;
      end
    end else begin
      pos_nxt   = pos_inc;
      idx_nxt   = idx_r + 2'd1;
      tag_nxt   = tag_cur;
      word_nxt  = word_cur;
      len_nxt   = len_cur;
      guess_nxt = start ? 1'b0 : guess_r;
      res.element_tag  = tag_cur;
      res.element_word = word_cur;
      if (do_finish) begin
        len_nxt            = fin_len;
        guess_nxt          = fin_guess;
        res.payload_length = fin_len;
        res.length_guessed = fin_guess;
        res.status         = tesp_pkg::ST_DONE;
        if (fin_len > remaining) begin
          res.status = tesp_pkg::ST_OVERRUN;
          halted_nxt = 1'b1;
        end else if (fin_len == 32'd0) begin
          res.end_of_element = 1'b1;
          phase_nxt          = PH_TAG;
        end else begin
          left_nxt  = fin_len;
          phase_nxt = PH_PAYLOAD;
        end
      end else begin
        if (field_done && (phase_r == PH_TAG)) begin
          phase_nxt = PH_WORD;
        end else if (field_done && (phase_r == PH_WORD)) begin
          len_nxt   = 32'd0;
          phase_nxt = PH_LEN;
        end
        if (remaining == 32'd0) begin
          res.status = tesp_pkg::ST_TRUNC;
          halted_nxt = 1'b1;
        end else begin
          res.status = tesp_pkg::ST_HEADER;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TAG;
      idx_r    <= 2'd0;
      tag_r    <= '0;
      word_r   <= '0;
      len_r    <= '0;
      guess_r  <= 1'b0;
      left_r   <= '0;
      pos_r    <= '0;
      halted_r <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      idx_r    <= idx_nxt;
      tag_r    <= tag_nxt;
      word_r   <= word_nxt;
      len_r    <= len_nxt;
      guess_r  <= guess_nxt;
      left_r   <= left_nxt;
      pos_r    <= pos_nxt;
      halted_r <= halted_nxt;
    end
  end

  // Once halted, stay halted until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt flag cleared without reset");

  // A halted parser reports every byte as ignored
  a_halt_ignores: assert property (@(posedge clk) disable iff (!rst_n)
    (step && halted_r) |-> (res.status == tesp_pkg::ST_IGNORED))
    else $error("byte parsed while halted");

  // Payload phase always has bytes left to count
  a_payload_left: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (left_r != 32'd0))
    else $error("payload phase with no bytes left");

endmodule

[rtl/tagged_element_stream_parser.sv]
// Top level of the tagged element stream parser: input stage, output stage, config.
//
// Usage:
//   The input channel (in_valid / in_stall / in_data_in) carries one raw byte of
//   the region per transaction. The output channel (out_valid / out_stall /
//   out_*) returns exactly one result transaction per input byte, in order.
//   cfg_wr_en / cfg_wr_data set region_length; write it only while the block
//   is idle. Writing it does not restart parsing.
// Path: an accepted byte sits in the input register; its result is then loaded
//   into the output register, which drives out_valid and the out_* fields.
// Throughput: one byte per cycle while the output is not stalled. Each byte needs
//   only byte-lane merges, the length mode decode and one subtract-and-compare
//   against the region size, all between the input and output registers.
// Reset (rst_n low, synchronous): both stages empty, parse state back to
//   reading a tag at region position zero, region_length zero.
// Stall: while out_stall holds a full output register, the input register
//   keeps its byte and in_stall is raised; a free output register lets both
//   stages advance together, so no transaction is lost or repeated.
module tagged_element_stream_parser (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_in,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_element_tag,
  output logic [31:0] out_element_word,
  output logic [31:0] out_payload_length,
  output logic [7:0]  out_payload_byte,
  output logic        out_end_of_element,
  output logic        out_length_guessed,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  logic              in_v_r;
  logic [7:0]        in_byte_r;
  logic              out_v_r;
  tesp_pkg::result_t out_r;
  tesp_pkg::result_t res;
  logic [31:0]       region_length_r;
  logic              step;

  // Advance the input stage whenever the output register is free or draining
  assign step     = in_v_r && !(out_v_r && out_stall);
  assign in_stall = in_v_r && out_v_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_length_r <= '0;
    end else if (cfg_wr_en) begin
      region_length_r <= cfg_wr_data;
    end
  end

  // Input register: hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      in_byte_r <= in_data_in;
    end
  end

  tesp_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .data_byte     (in_byte_r),
    .region_length (region_length_r),
    .res           (res)
  );

  // Output register: load on step, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (step) begin
      out_v_r <= 1'b1;
    end else if (!out_stall) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_v_r;
  assign out_status         = out_r.status;
  assign out_element_tag    = out_r.element_tag;
  assign out_element_word   = out_r.element_word;
  assign out_payload_length = out_r.payload_length;
  assign out_payload_byte   = out_r.payload_byte;
  assign out_end_of_element = out_r.end_of_element;
  assign out_length_guessed = out_r.length_guessed;

  // Stall toward the source only when a byte is actually held
  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_v_r)
    else $error("input stalled with empty input stage");

  // A stalled result must not be overwritten
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_stall) |-> !step)
    else $error("output register overwritten while stalled");

endmodule
